@@ rtl/core/sat_assignment_trail_assert.svh @@
// Assertion macros for the trail RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SAT_ASSIGNMENT_TRAIL_ASSERT_SVH
`define SAT_ASSIGNMENT_TRAIL_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SAT_TRAIL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAT_TRAIL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SAT_TRAIL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SAT_TRAIL_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/sat_trail_pkg.sv @@
// Shared types and constants for the assignment trail.
// No dependencies; imported by every trail module.
`timescale 1ns / 1ps

package sat_trail_pkg;

  localparam int VAR_COUNT = 1023;
  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = 10;
  localparam int TRAIL_CAP = 1023;

  typedef enum logic [1:0] {
    OP_DECIDE  = 2'd0,
    OP_IMPLIED = 2'd1,
    OP_POP     = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_REJECT    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY_POP = 2'd2;

  localparam logic [1:0] VAL_UNASSIGNED = 2'd0;
  localparam logic [1:0] VAL_FALSE      = 2'd1;
  localparam logic [1:0] VAL_TRUE       = 2'd2;

  localparam logic [1:0] PHASE_UNKNOWN = 2'd0;
  localparam logic [1:0] PHASE_FALSE   = 2'd1;
  localparam logic [1:0] PHASE_TRUE    = 2'd2;

  localparam logic [2:0]  ADDR_AGILITY_DECAY  = 3'd0;
  localparam logic [15:0] AGILITY_DECAY_RESET = 16'd65208;

  typedef struct packed {
    logic [ADDR_W-1:0] vid;
    logic              positive;
    logic              decision;
    logic [15:0]       reason;
  } trail_entry_t;

  // per-variable word: current value and saved phase
  typedef struct packed {
    logic [1:0] value;
    logic [1:0] phase;
  } var_word_t;

endpackage

@@ rtl/core/sat_trail_agility.sv @@
// Agility average update in Q0.16: decay, then add (1 - g) on a phase flip.
// Depends on sat_trail_pkg.
`timescale 1ns / 1ps

module sat_trail_agility import sat_trail_pkg::*; (
  input  logic [15:0] avg,
  input  logic [15:0] decay,
  input  logic        flip,
  output logic [15:0] avg_next
);

  logic [31:0] prod;
  logic [15:0] scaled;
  logic [16:0] gain;
  logic [16:0] sum;

  assign prod   = avg * decay;
  assign scaled = prod[31:16];
  // 65536 - g, between 1 and 65536
  assign gain   = 17'h10000 - {1'b0, decay};
  assign sum    = {1'b0, scaled} + gain;

  always_comb begin
    if (!flip) begin
      avg_next = scaled;
    end else if (sum[16]) begin
      avg_next = 16'hFFFF;
    end else begin
      avg_next = sum[15:0];
    end
  end

endmodule

@@ rtl/core/sat_assignment_trail.sv @@
// Assignment trail of a CDCL solver with phase saving and agility tracking.
// Depends on sat_trail_pkg, sat_trail_agility and sat_assignment_trail_assert.svh.
//
//   channel   | handshake                       | payload
//   ----------+---------------------------------+------------------------------------
//   request   | start, busy (accept: start&!busy)| operation, literal_var,
//             |                                 | literal_positive, reason_id
//   result    | done (one-cycle strobe)         | status, popped_*, decision_level,
//             |                                 | trail_length, agility
//   config    | APB psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// One request per cycle while busy is low. An accepted request is registered into the
// execute stage as the variable and trail memories are read; the execute stage then
// writes them back and registers its result onto the outputs. Back-to-back hazards on
// the two memories are covered by write-to-read forwarding.
// After rst the variable memory is cleared one entry per cycle, and busy stays high
// until every entry has been cleared. Results cannot be stalled.
`timescale 1ns / 1ps

`include "sat_assignment_trail_assert.svh"

module sat_assignment_trail import sat_trail_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [ADDR_W-1:0]   literal_var,
  input  logic                literal_positive,
  input  logic [15:0]         reason_id,
  output logic                done,
  output logic [1:0]          status,
  output logic [ADDR_W-1:0]   popped_var,
  output logic                popped_positive,
  output logic                popped_was_decision,
  output logic [15:0]         popped_reason,
  output logic [ADDR_W-1:0]   decision_level,
  output logic [ADDR_W-1:0]   trail_length,
  output logic [15:0]         agility,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic accept;

  // configuration
  logic [15:0] agility_decay;

  // architectural state
  logic [ADDR_W-1:0] trail_top;
  logic [ADDR_W-1:0] current_level;
  logic [15:0]       agility_average;

  // clear pass
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // execute stage
  logic              s1_valid;
  op_t               s1_op;
  logic [ADDR_W-1:0] s1_vid;
  logic              s1_pos;
  logic [15:0]       s1_reason;

  // memories
  var_word_t    var_mem   [DEPTH];
  trail_entry_t trail_mem [DEPTH];
  var_word_t    var_rdata;
  trail_entry_t trail_rdata;
  logic         var_fwd_hit;
  var_word_t    var_fwd_word;
  logic         trail_fwd_hit;
  trail_entry_t trail_fwd_entry;

  // execute logic
  var_word_t         var_word;
  trail_entry_t      top_entry;
  logic              bad_var;
  logic              push_ok;
  logic              flip;
  logic [15:0]       agility_calc;
  logic [ADDR_W-1:0] trail_top_next;
  logic [ADDR_W-1:0] current_level_next;
  logic [15:0]       agility_average_next;
  logic [1:0]        status_next;
  logic [ADDR_W-1:0] popped_var_next;
  logic              popped_positive_next;
  logic              popped_was_decision_next;
  logic [15:0]       popped_reason_next;
  logic              var_we;
  logic [ADDR_W-1:0] var_waddr;
  var_word_t         var_wdata;
  logic              trail_we;
  trail_entry_t      trail_wdata;
  logic [ADDR_W-1:0] trail_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  var_word_t         mem_wdata;

  assign busy   = clearing;
  assign accept = start && !busy;
  assign pready = 1'b1;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      agility_decay <= AGILITY_DECAY_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_AGILITY_DECAY) begin
      agility_decay <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_AGILITY_DECAY) begin
      prdata = {16'd0, agility_decay};
    end
  end

  // ---------------- execute stage ----------------
  assign var_word  = var_fwd_hit ? var_fwd_word : var_rdata;
  assign top_entry = trail_fwd_hit ? trail_fwd_entry : trail_rdata;

  assign bad_var = (s1_vid == '0) || (int'(s1_vid) > VAR_COUNT);
  assign push_ok = !bad_var && var_word.value == VAL_UNASSIGNED &&
                   int'(trail_top) < TRAIL_CAP;
  assign flip    = (s1_pos && var_word.phase == PHASE_FALSE) ||
                   (!s1_pos && var_word.phase == PHASE_TRUE);

  sat_trail_agility u_agility (
    .avg      (agility_average),
    .decay    (agility_decay),
    .flip     (flip),
    .avg_next (agility_calc)
  );

  always_comb begin
    trail_top_next           = trail_top;
    current_level_next       = current_level;
    agility_average_next     = agility_average;
    status_next              = STATUS_OK;
    popped_var_next          = '0;
    popped_positive_next     = 1'b0;
    popped_was_decision_next = 1'b0;
    popped_reason_next       = '0;
    var_we                   = 1'b0;
    var_waddr                = s1_vid;
    var_wdata                = var_word;
    trail_we                 = 1'b0;
    trail_wdata.vid          = s1_vid;
    trail_wdata.positive     = s1_pos;
    trail_wdata.decision     = (s1_op == OP_DECIDE);
    trail_wdata.reason       = (s1_op == OP_DECIDE) ? 16'd0 : s1_reason;
    if (s1_valid) begin
      case (s1_op)
        OP_DECIDE, OP_IMPLIED: begin
          if (push_ok) begin
            var_we          = 1'b1;
            var_wdata.value = s1_pos ? VAL_TRUE : VAL_FALSE;
            trail_we        = 1'b1;
            trail_top_next  = trail_top + 10'd1;
            if (s1_op == OP_DECIDE) begin
              current_level_next = current_level + 10'd1;
            end else begin
              agility_average_next = agility_calc;
            end
          end else begin
            status_next = STATUS_REJECT;
          end
        end
        OP_POP: begin
          if (trail_top != '0) begin
            trail_top_next  = trail_top - 10'd1;
            var_we          = 1'b1;
            var_waddr       = top_entry.vid;
            var_wdata.value = VAL_UNASSIGNED;
            var_wdata.phase = top_entry.positive ? PHASE_TRUE : PHASE_FALSE;
            // the entry below a decision sits one level lower; below an implied
            // entry the level is unchanged
            if (top_entry.decision) begin
              current_level_next = current_level - 10'd1;
            end
            popped_var_next          = top_entry.vid;
            popped_positive_next     = top_entry.positive;
            popped_was_decision_next = top_entry.decision;
            popped_reason_next       = top_entry.reason;
          end else begin
            status_next = STATUS_EMPTY_POP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a pop reads the entry that will be on top once the executing request retires
  assign trail_raddr = trail_top_next - 10'd1;

  // ---------------- memories ----------------
  assign mem_we    = clearing || var_we;
  assign mem_waddr = clearing ? clr_addr : var_waddr;
  assign mem_wdata = clearing ? var_word_t'('0) : var_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      var_mem[mem_waddr] <= mem_wdata;
    end
    var_rdata    <= var_mem[literal_var];
    var_fwd_hit  <= var_we && var_waddr == literal_var;
    var_fwd_word <= var_wdata;
  end

  always_ff @(posedge clk) begin
    if (trail_we) begin
      trail_mem[trail_top] <= trail_wdata;
    end
    trail_rdata     <= trail_mem[trail_raddr];
    trail_fwd_hit   <= trail_we && trail_top == trail_raddr;
    trail_fwd_entry <= trail_wdata;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing        <= 1'b1;
      clr_addr        <= '0;
      s1_valid        <= 1'b0;
      done            <= 1'b0;
      trail_top       <= '0;
      current_level   <= '0;
      agility_average <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 10'd1;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      s1_valid        <= accept;
      done            <= s1_valid;
      trail_top       <= trail_top_next;
      current_level   <= current_level_next;
      agility_average <= agility_average_next;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= op_t'(operation);
      s1_vid    <= literal_var;
      s1_pos    <= literal_positive;
      s1_reason <= reason_id;
    end
    if (s1_valid) begin
      status              <= status_next;
      popped_var          <= popped_var_next;
      popped_positive     <= popped_positive_next;
      popped_was_decision <= popped_was_decision_next;
      popped_reason       <= popped_reason_next;
      decision_level      <= current_level_next;
      trail_length        <= trail_top_next;
      agility             <= agility_average_next;
    end
  end

  // ---------------- checks ----------------
  `SAT_TRAIL_ASSERT_IMP(a_no_exec_while_clearing, clk, rst, clearing, !s1_valid, "request executing during clear pass")
  `SAT_TRAIL_ASSERT_NXT(a_exec_gives_result, clk, rst, s1_valid, done, "executed request produced no result")
  `SAT_TRAIL_ASSERT_IMP(a_level_within_trail, clk, rst, 1'b1, current_level <= trail_top, "decision level exceeds trail length")
  `SAT_TRAIL_ASSERT_IMP(a_empty_pop_len, clk, rst, done && status == STATUS_EMPTY_POP, trail_length == '0, "empty pop reported with entries on trail")
  `SAT_TRAIL_ASSERT_NXT(a_pop_shrinks, clk, rst, s1_valid && s1_op == OP_POP && trail_top != '0, trail_top == $past(trail_top) - 10'd1, "pop did not shrink trail by one")

endmodule

@@ sim/sat_trail_checker.sv @@
// Checker for sat_assignment_trail: watches the request, result and APB channels,
// keeps its own trail model and compares each result in order. Uses sat_trail_pkg.
`timescale 1ns / 1ps

module sat_trail_checker import sat_trail_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        operation,
  input  logic [ADDR_W-1:0] literal_var,
  input  logic              literal_positive,
  input  logic [15:0]       reason_id,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [ADDR_W-1:0] popped_var,
  input  logic              popped_positive,
  input  logic              popped_was_decision,
  input  logic [15:0]       popped_reason,
  input  logic [ADDR_W-1:0] decision_level,
  input  logic [ADDR_W-1:0] trail_length,
  input  logic [15:0]       agility,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                errors,
  output int                accepted,
  output int                pending
);

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] pvar;
    logic              ppos;
    logic              pdec;
    logic [15:0]       preason;
    logic [ADDR_W-1:0] level;
    logic [ADDR_W-1:0] length;
    logic [15:0]       agil;
  } trail_result_t;

  logic [1:0]        var_val   [DEPTH];
  logic [1:0]        var_phase [DEPTH];
  trail_entry_t      trail     [DEPTH];
  logic [ADDR_W-1:0] trail_lvl [DEPTH];
  logic [ADDR_W:0]   depth;
  logic [ADDR_W-1:0] level;
  logic [15:0]       agil_avg;
  logic [15:0]       decay;
  trail_result_t     pending_results [$];

  // a' = floor(a*g/2^16), plus (1-g) on a phase flip, saturating
  function automatic logic [15:0] next_agility(logic [15:0] cur, logic [15:0] g,
                                               logic flip);
    logic [31:0] prod;
    logic [16:0] sum;
    prod = cur * g;
    sum = {1'b0, prod[31:16]};
    if (flip) sum = sum + (17'h10000 - {1'b0, g});
    return (sum > 17'hFFFF) ? 16'hFFFF : sum[15:0];
  endfunction

  function automatic trail_result_t trail_step(op_t op, logic [ADDR_W-1:0] vid,
                                               logic pos, logic [15:0] reason);
    trail_result_t r;
    trail_entry_t  e;
    logic          flip;
    r = '0;
    case (op)
      OP_DECIDE, OP_IMPLIED: begin
        if (vid == 0 || vid > VAR_COUNT || var_val[vid] != VAL_UNASSIGNED ||
            depth >= TRAIL_CAP) begin
          r.status = STATUS_REJECT;
        end else begin
          if (op == OP_DECIDE) begin
            level = level + 1'b1;
          end else begin
            flip = (pos && var_phase[vid] == PHASE_FALSE) ||
                   (!pos && var_phase[vid] == PHASE_TRUE);
            agil_avg = next_agility(agil_avg, decay, flip);
          end
          e.vid      = vid;
          e.positive = pos;
          e.decision = (op == OP_DECIDE);
          e.reason   = (op == OP_DECIDE) ? 16'h0 : reason;
          trail[depth[ADDR_W-1:0]]     = e;
          trail_lvl[depth[ADDR_W-1:0]] = level;
          var_val[vid] = pos ? VAL_TRUE : VAL_FALSE;
          depth = depth + 1'b1;
        end
      end
      OP_POP: begin
        if (depth == 0) begin
          r.status = STATUS_EMPTY_POP;
        end else begin
          depth = depth - 1'b1;
          e = trail[depth[ADDR_W-1:0]];
          var_phase[e.vid] = (var_val[e.vid] == VAL_TRUE) ? PHASE_TRUE : PHASE_FALSE;
          var_val[e.vid] = VAL_UNASSIGNED;
          level = (depth == 0) ? '0 : trail_lvl[depth[ADDR_W-1:0] - 1'b1];
          r.pvar    = e.vid;
          r.ppos    = e.positive;
          r.pdec    = e.decision;
          r.preason = e.reason;
        end
      end
      default: ;
    endcase
    r.level  = level;
    r.length = depth[ADDR_W-1:0];
    r.agil   = agil_avg;
    return r;
  endfunction

  function automatic string fmt_result(trail_result_t r);
    return $sformatf("st=%0d pv=%0d pp=%0d pd=%0d pr=%0d lvl=%0d len=%0d ag=%0d",
                     r.status, r.pvar, r.ppos, r.pdec, r.preason, r.level, r.length,
                     r.agil);
  endfunction

  always @(posedge clk) begin : watch
    trail_result_t seen;
    trail_result_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        var_val[i]   = VAL_UNASSIGNED;
        var_phase[i] = PHASE_UNKNOWN;
      end
      depth    = '0;
      level    = '0;
      agil_avg = '0;
      decay    = AGILITY_DECAY_RESET;
      pending_results.delete();
    end else begin
      if (done) begin
        seen = {status, popped_var, popped_positive, popped_was_decision, popped_reason,
                decision_level, trail_length, agility};
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending: %s", $time, fmt_result(seen));
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            errors++;
            $display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
                     fmt_result(want), fmt_result(seen));
          end
        end
      end
      if (start && !busy) begin
        pending_results.insert(pending_results.size(),
                               trail_step(op_t'(operation), literal_var,
                                          literal_positive, reason_id));
        accepted++;
      end
      if (psel && penable && pready && paddr == ADDR_AGILITY_DECAY) begin
        if (pwrite) begin
          decay = pwdata[15:0];
        end else if (prdata !== {16'h0, decay}) begin
          errors++;
          $display("%0t: agility_decay read expected %h actual %h", $time,
                   {16'h0, decay}, prdata);
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

@@ sim/tb_sat_assignment_trail.sv @@
// Testbench top for sat_assignment_trail: drives requests and APB register access,
// gives the verdict. Depends on sat_trail_pkg, the block and sat_trail_checker.
`timescale 1ns / 1ps

module tb_sat_assignment_trail import sat_trail_pkg::*;;

  localparam int CYCLE_LIMIT = 300000;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        operation = '0;
  logic [ADDR_W-1:0] literal_var = '0;
  logic              literal_positive = 1'b0;
  logic [15:0]       reason_id = '0;
  logic              done;
  logic [1:0]        status;
  logic [ADDR_W-1:0] popped_var;
  logic              popped_positive;
  logic              popped_was_decision;
  logic [15:0]       popped_reason;
  logic [ADDR_W-1:0] decision_level;
  logic [ADDR_W-1:0] trail_length;
  logic [15:0]       agility;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int errors;
  int accepted;
  int pending;
  int cycle_count = 0;
  bit steady_run = 1'b0;

  sat_assignment_trail uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .literal_var(literal_var),
    .literal_positive(literal_positive), .reason_id(reason_id),
    .done(done), .status(status), .popped_var(popped_var),
    .popped_positive(popped_positive), .popped_was_decision(popped_was_decision),
    .popped_reason(popped_reason), .decision_level(decision_level),
    .trail_length(trail_length), .agility(agility),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sat_trail_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .literal_var(literal_var),
    .literal_positive(literal_positive), .reason_id(reason_id),
    .done(done), .status(status), .popped_var(popped_var),
    .popped_positive(popped_positive), .popped_was_decision(popped_was_decision),
    .popped_reason(popped_reason), .decision_level(decision_level),
    .trail_length(trail_length), .agility(agility),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .accepted(accepted), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sat_assignment_trail: errors");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    if (steady_run) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // gap first, then hold the request until the checker sees it accepted
  task automatic send(op_t op, logic [ADDR_W-1:0] vid, logic pos, logic [15:0] reason);
    int gap;
    int seen;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seen = accepted;
    operation        <= op;
    literal_var      <= vid;
    literal_positive <= pos;
    reason_id        <= reason;
    start            <= 1'b1;
    do @(negedge clk); while (accepted == seen);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_decay(logic [15:0] g);
    wait_idle();
    apb_access(1'b1, ADDR_AGILITY_DECAY, {16'h0, g});
    apb_access(1'b0, ADDR_AGILITY_DECAY, '0);
  endtask

  task automatic random_request();
    int r;
    int pick;
    op_t op;
    logic [ADDR_W-1:0] vid;
    r = $urandom_range(99);
    if (r < 20) op = OP_DECIDE;
    else if (r < 58) op = OP_IMPLIED;
    else if (r < 94) op = OP_POP;
    else op = OP_NOP;
    // mostly a small pool so phases get reused and assignments collide
    pick = $urandom_range(99);
    if (pick < 4) vid = '0;
    else if (pick < 14) vid = ADDR_W'($urandom_range(VAR_COUNT, 1));
    else vid = ADDR_W'($urandom_range(40, 1));
    send(op, vid, 1'($urandom_range(1)), 16'($urandom_range(65535)));
  endtask

  initial begin : stimulus
    logic [15:0] decay_plan [4];
    decay_plan[0] = 16'h0000;
    decay_plan[1] = 16'hFFFF;
    decay_plan[2] = 16'h8000;
    decay_plan[3] = 16'($urandom_range(65535));

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_access(1'b0, ADDR_AGILITY_DECAY, '0);

    // directed: empty pop, nop, out of range, double assign, phase flips
    send(OP_POP, 10'd3, 1'b1, 16'h1234);
    send(OP_NOP, 10'd0, 1'b0, 16'h0);
    send(OP_DECIDE, 10'd1, 1'b1, 16'hFFFF);
    send(OP_IMPLIED, 10'd1023, 1'b0, 16'hFFFF);
    send(OP_IMPLIED, 10'd0, 1'b1, 16'h0001);
    send(OP_DECIDE, 10'd1, 1'b0, 16'h0);
    send(OP_IMPLIED, 10'd2, 1'b1, 16'h0000);
    send(OP_NOP, 10'd1023, 1'b1, 16'hFFFF);
    send(OP_POP, 10'd0, 1'b0, 16'h0);
    send(OP_POP, 10'd0, 1'b0, 16'h0);
    send(OP_POP, 10'd0, 1'b0, 16'h0);
    send(OP_IMPLIED, 10'd1023, 1'b1, 16'h0001);
    send(OP_IMPLIED, 10'd1, 1'b0, 16'h8000);
    send(OP_IMPLIED, 10'd2, 1'b1, 16'h7FFF);
    send(OP_DECIDE, 10'd5, 1'b0, 16'h0);
    send(OP_DECIDE, 10'd6, 1'b1, 16'h0);
    send(OP_IMPLIED, 10'd512, 1'b1, 16'hAAAA);
    repeat (6) send(OP_POP, 10'd0, 1'b0, 16'h0);
    send(OP_NOP, 10'd0, 1'b0, 16'h0);

    foreach (decay_plan[i]) begin
      set_decay(decay_plan[i]);
      steady_run = ($urandom_range(2) == 0);
      repeat (100) random_request();
    end

    // every variable once: trail ends up full, then pushes are refused
    set_decay(16'($urandom_range(65535)));
    for (int v = 1; v <= VAR_COUNT; v++) begin
      if (v % 128 == 0) steady_run = 1'($urandom_range(1));
      send(($urandom_range(3) == 0) ? OP_DECIDE : OP_IMPLIED, ADDR_W'(v),
           1'($urandom_range(1)), 16'($urandom_range(65535)));
    end
    send(OP_IMPLIED, ADDR_W'($urandom_range(VAR_COUNT, 1)), 1'b1,
         16'($urandom_range(65535)));
    send(OP_DECIDE, ADDR_W'($urandom_range(VAR_COUNT, 1)), 1'b0, 16'h0);
    repeat (20) send(OP_POP, 10'd0, 1'b0, 16'h0);

    wait_idle();
    repeat (6) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_sat_assignment_trail: clean");
    end else begin
      $display("tb_sat_assignment_trail: errors");
    end
    $finish;
  end

endmodule
